>>> rtl/core/life_pkg.sv
package life_pkg;

    // Command codes carried by an input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Width of the configuration registers and data
    localparam int SIZE_W = 7;

    // B3/S23 neighbour counts
    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    // Window control from the sequencer to the column cells
    typedef struct packed {
        logic clear;
        logic shift;
    } win_ctrl_t;

endpackage

>>> rtl/core/life_ram.sv
module life_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one row, read one row with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/life_col_cell.sv
module life_col_cell (
    input  logic                clk,
    input  life_pkg::win_ctrl_t ctrl,
    input  logic                en,
    input  logic                din,
    input  logic [2:0]          left_vis,
    input  logic [2:0]          right_vis,
    output logic [2:0]          vis,
    output logic                wr_bit
);

    logic                        above_reg;
    logic                        above_next;
    logic                        cur_reg;
    logic                        cur_next;
    logic                        below_reg;
    logic                        below_next;
    logic [life_pkg::NBR_W-1:0]  count;
    logic                        life;

    // Shift the three-row window down by one row, or empty it
    always_comb
    begin
        above_next = above_reg;
        cur_next   = cur_reg;
        below_next = below_reg;
        if (ctrl.clear)
        begin
            above_next = 1'b0;
            cur_next   = 1'b0;
            below_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            above_next = cur_reg;
            cur_next   = below_reg;
            below_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
        cur_reg   <= cur_next;
        below_reg <= below_next;
    end

    // Columns outside the grid in use look dead to their neighbors
    assign vis = {above_reg, cur_reg, below_reg} & {3{en}};

    // Count the eight neighbors of the middle row
    assign count = life_pkg::NBR_W'(left_vis[0]) + life_pkg::NBR_W'(left_vis[1])
                 + life_pkg::NBR_W'(left_vis[2]) + life_pkg::NBR_W'(right_vis[0])
                 + life_pkg::NBR_W'(right_vis[1]) + life_pkg::NBR_W'(right_vis[2])
                 + life_pkg::NBR_W'(vis[2]) + life_pkg::NBR_W'(vis[0]);

    assign life = (count == life_pkg::BIRTH_COUNT)
               || (vis[1] && (count == life_pkg::SURVIVE_COUNT));

    // Keep the old bit in columns outside the grid in use
    assign wr_bit = en ? life : cur_reg;

endmodule

>>> rtl/core/life_generation_step.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// in       | in_valid/in_stall  | command, row, col, write_alive
// out      | out_valid/out_stall| read_alive, out_of_range
// cfg      | cfg_write_en       | cfg_index, cfg_data
//
// One word at a time; once its result loads, the next word can be taken.
// Results: a read or write in range goes through ST_ACCESS to ST_DONE, an
// out-of-range or unused word goes straight to ST_DONE, and a step sweeps the
// rows (one row per cycle through the column cells) before ST_DONE. After reset
// a clearing pass writes all min(MAX_ROWS, 127) rows dead with in_stall high.
// A result held by out_stall does not block the next word; a second result waits in the sequencer.
module life_generation_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [5:0] row,
    input  logic [5:0] col,
    input  logic       write_alive,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       read_alive,
    output logic       out_of_range,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int ROW_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int RA_W    = $clog2(ROW_LIM);
    localparam int CNT_W   = $clog2(ROW_LIM + 2);
    localparam int COL_IW  = $clog2(MAX_COLS);
    localparam int SW      = life_pkg::SIZE_W;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_STEP   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SW-1:0]         rows_in_use_reg;
    logic [SW-1:0]         cols_in_use_reg;
    logic [RA_W-1:0]       clr_addr_reg;
    logic [RA_W-1:0]       clr_addr_next;
    life_pkg::cmd_t        cmd_reg;
    life_pkg::cmd_t        cmd_next;
    logic [5:0]            row_reg;
    logic [5:0]            row_next;
    logic [5:0]            col_reg;
    logic [5:0]            col_next;
    logic                  wv_reg;
    logic                  wv_next;
    logic [CNT_W-1:0]      sweep_reg;
    logic [CNT_W-1:0]      sweep_next;
    logic                  load_vld_reg;
    logic                  load_vld_next;
    logic                  load_live_reg;
    logic                  load_live_next;
    logic [CNT_W-1:0]      load_row_reg;
    logic                  win_vld_reg;
    logic [CNT_W-1:0]      win_row_reg;
    logic                  res_rd_reg;
    logic                  res_rd_next;
    logic                  res_oor_reg;
    logic                  res_oor_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  read_alive_reg;
    logic                  read_alive_next;
    logic                  oor_reg;
    logic                  oor_next;

    logic [SW-1:0]         nr7;
    logic [SW-1:0]         nc7;
    logic [CNT_W-1:0]      nr;
    logic                  accept;
    logic                  in_inside;
    logic [RA_W+5:0]       in_row_wide;
    logic [RA_W+5:0]       row_wide;
    logic [COL_IW+5:0]     col_wide;
    logic [RA_W-1:0]       in_row_addr;
    logic [RA_W-1:0]       row_addr;
    logic [COL_IW-1:0]     col_idx;
    logic                  issue;
    logic                  wb_en;
    logic [CNT_W-1:0]      wb_row;
    logic                  step_end;
    logic                  out_free;

    logic                  ram_we;
    logic [RA_W-1:0]       ram_waddr;
    logic [MAX_COLS-1:0]   ram_wdata;
    logic [RA_W-1:0]       ram_raddr;
    logic [MAX_COLS-1:0]   ram_rdata;
    logic [MAX_COLS-1:0]   merged_row;
    logic [MAX_COLS-1:0]   col_en;
    logic [MAX_COLS-1:0]   cell_din;
    logic [MAX_COLS-1:0]   cell_wr;
    logic [2:0]            cell_vis [MAX_COLS];
    life_pkg::win_ctrl_t   win_ctrl;

    // Saturate the size in use; a size of zero counts as one
    assign nr7 = (rows_in_use_reg == '0) ? SW'(1)
               : ((rows_in_use_reg > SW'(ROW_LIM)) ? SW'(ROW_LIM) : rows_in_use_reg);
    assign nc7 = (cols_in_use_reg == '0) ? SW'(1)
               : ((cols_in_use_reg > SW'(MAX_COLS)) ? SW'(MAX_COLS) : cols_in_use_reg);
    assign nr  = CNT_W'(nr7);

    // Address and bit index from the coordinate fields
    assign in_row_wide = {{RA_W{1'b0}}, row};
    assign in_row_addr = in_row_wide[RA_W-1:0];
    assign row_wide    = {{RA_W{1'b0}}, row_reg};
    assign row_addr    = row_wide[RA_W-1:0];
    assign col_wide    = {{COL_IW{1'b0}}, col_reg};
    assign col_idx     = col_wide[COL_IW-1:0];

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_inside = (SW'(row) < nr7) && (SW'(col) < nc7);
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= SW'(64);
            cols_in_use_reg <= SW'(64);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                life_pkg::CFG_ROWS: rows_in_use_reg <= cfg_data;
                life_pkg::CFG_COLS: cols_in_use_reg <= cfg_data;
                default:            rows_in_use_reg <= rows_in_use_reg;
            endcase
        end
    end

    // Sweep the grid one row per cycle during a step
    assign issue     = (state_reg == ST_STEP) && (sweep_reg <= nr);
    assign wb_en     = (state_reg == ST_STEP) && win_vld_reg && (win_row_reg != '0);
    assign wb_row    = win_row_reg - CNT_W'(1);
    assign step_end  = win_vld_reg && (win_row_reg == nr);
    assign win_ctrl.clear = accept && (life_pkg::cmd_t'(command) == life_pkg::CMD_STEP);
    assign win_ctrl.shift = load_vld_reg;
    assign cell_din  = load_live_reg ? ram_rdata : '0;

    // Replace one bit of the fetched row
    always_comb
    begin
        merged_row          = ram_rdata;
        merged_row[col_idx] = wv_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wv_next        = wv_reg;
        sweep_next     = sweep_reg;
        res_rd_next    = res_rd_reg;
        res_oor_next   = res_oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = row_addr;
        ram_wdata      = merged_row;
        ram_raddr      = sweep_reg[RA_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + RA_W'(1);
                if (clr_addr_reg == RA_W'(ROW_LIM - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = in_row_addr;
                if (accept)
                begin
                    cmd_next     = life_pkg::cmd_t'(command);
                    row_next     = row;
                    col_next     = col;
                    wv_next      = write_alive;
                    res_rd_next  = 1'b0;
                    res_oor_next = 1'b0;
                    sweep_next   = '0;
                    unique case (life_pkg::cmd_t'(command))
                        life_pkg::CMD_WRITE,
                        life_pkg::CMD_READ:
                        begin
                            if (in_inside)
                            begin
                                state_next = ST_ACCESS;
                            end
                            else
                            begin
                                res_oor_next = 1'b1;
                                state_next   = ST_DONE;
                            end
                        end
                        life_pkg::CMD_STEP:
                        begin
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (cmd_reg == life_pkg::CMD_WRITE)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    res_rd_next = ram_rdata[col_idx];
                end
                state_next = ST_DONE;
            end
            ST_STEP:
            begin
                if (issue)
                begin
                    sweep_next = sweep_reg + CNT_W'(1);
                end
                ram_we    = wb_en;
                ram_waddr = wb_row[RA_W-1:0];
                ram_wdata = cell_wr;
                if (step_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load_vld_next  = issue;
    assign load_live_next = sweep_reg < nr;

    // Drive the output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        read_alive_next = read_alive_reg;
        oor_next        = oor_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next  = 1'b1;
            read_alive_next = res_rd_reg;
            oor_next        = res_oor_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            load_vld_reg  <= 1'b0;
            win_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            load_vld_reg  <= load_vld_next;
            win_vld_reg   <= load_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        wv_reg         <= wv_next;
        sweep_reg      <= sweep_next;
        load_live_reg  <= load_live_next;
        load_row_reg   <= sweep_reg;
        win_row_reg    <= load_row_reg;
        res_rd_reg     <= res_rd_next;
        res_oor_reg    <= res_oor_next;
        read_alive_reg <= read_alive_next;
        oor_reg        <= oor_next;
    end

    assign out_valid    = out_valid_reg;
    assign read_alive   = read_alive_reg;
    assign out_of_range = oor_reg;

    // Row store
    life_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (ROW_LIM)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Chain of column cells, each sees its left and right neighbor
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        logic [2:0] left_vis;
        logic [2:0] right_vis;

        assign col_en[c] = (SW'(c) < nc7);

        if (c == 0)
        begin : g_left_edge
            assign left_vis = 3'b000;
        end
        else
        begin : g_left
            assign left_vis = cell_vis[c-1];
        end

        if (c == MAX_COLS - 1)
        begin : g_right_edge
            assign right_vis = 3'b000;
        end
        else
        begin : g_right
            assign right_vis = cell_vis[c+1];
        end

        life_col_cell u_cell (
            .clk       (clk),
            .ctrl      (win_ctrl),
            .en        (col_en[c]),
            .din       (cell_din[c]),
            .left_vis  (left_vis),
            .right_vis (right_vis),
            .vis       (cell_vis[c]),
            .wr_bit    (cell_wr[c])
        );
    end

endmodule

>>> rtl/core/life_checker.sv
module life_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] command,
    input logic [5:0] row,
    input logic [5:0] col,
    input logic       write_alive,
    input logic       out_valid,
    input logic       out_stall,
    input logic       read_alive,
    input logic       out_of_range,
    input logic       cfg_write_en,
    input logic       cfg_index,
    input logic [6:0] cfg_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_alive) && $stable(out_of_range))
        else $error("stalled result word changed");

    // Never report a live cell on an out-of-range access
    a_oor_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(read_alive && out_of_range))
        else $error("live cell reported with out_of_range");

    // Refuse command words while in reset (state held in ST_CLEAR)
    a_reset_stall: assert property (@(posedge clk)
        !rst_n |-> in_stall)
        else $error("command word taken during reset");

    // Take one command word at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command word taken while busy");

endmodule

bind life_generation_step life_checker u_life_checker (.*);
